@@ hw/rtl/lru_page_window_mapper_core_defines.svh @@
// Assertion macros shared by the page window mapper RTL.
`ifndef LRU_PAGE_WINDOW_MAPPER_CORE_DEFINES_SVH
`define LRU_PAGE_WINDOW_MAPPER_CORE_DEFINES_SVH

// Check that cond holds in the same cycle whenever trig holds.
`define LPWM_ASSERT_NOW(label, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error("lpwm check failed");

// Check that cond holds in the cycle after trig holds.
`define LPWM_ASSERT_NEXT(label, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error("lpwm check failed");

`endif

@@ hw/rtl/lpwm_pkg.sv @@
// Types, constants and codes of the page window mapper.
`timescale 1ns / 1ps
package lpwm_pkg;

	localparam int NUM_PAGES = 1024;
	localparam int NUM_SLOTS = 16;
	localparam int PAGE_BITS = 12;
	localparam int PAGE_W    = $clog2(NUM_PAGES);
	localparam int SLOT_W    = $clog2(NUM_SLOTS);
	localparam int USED_W    = $clog2(NUM_SLOTS + 1);
	localparam int COUNT_W   = $clog2(NUM_PAGES + 1);
	localparam int ADDR_W    = 32;
	localparam int AVAIL_W   = 5;
	localparam int STATUS_W  = 2;

	localparam logic REG_WINDOW_BASE     = 1'b0;
	localparam logic REG_SLOTS_AVAILABLE = 1'b1;

	localparam logic ACT_MAP    = 1'b0;
	localparam logic ACT_UNLOCK = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NO_EVICT = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_UNMAPPED = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_EVICT,
		ST_INSTALL,
		ST_ADDR,
		ST_DONE
	} lpwm_state_t;

	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_INC,
		ALU_DEC
	} lpwm_alu_op_t;

	typedef struct packed {
		lpwm_alu_op_t        op;
		logic [ADDR_W-1:0] a;
		logic [ADDR_W-1:0] b;
	} lpwm_alu_req_t;

	typedef struct packed {
		logic              mapped;
		logic              unlocked;
		logic [SLOT_W-1:0] slot;
	} lpwm_entry_t;

endpackage

@@ hw/rtl/lpwm_alu.sv @@
// Shared adder used for addresses and for counter steps.
`timescale 1ns / 1ps
module lpwm_alu (
	input  lpwm_pkg::lpwm_alu_req_t        req,
	output logic [lpwm_pkg::ADDR_W-1:0] y
);

	logic [lpwm_pkg::ADDR_W-1:0] operand;

	always_comb begin
		unique case (req.op)
			lpwm_pkg::ALU_ADD: operand = req.b;
			lpwm_pkg::ALU_INC: operand = lpwm_pkg::ADDR_W'(1);
			lpwm_pkg::ALU_DEC: operand = ~lpwm_pkg::ADDR_W'(0);
			default:           operand = req.b;
		endcase
	end

	assign y = req.a + operand;

endmodule

@@ hw/rtl/lru_page_window_mapper_core.sv @@
// Top level of the LRU page window mapper: sequencer, page tables and LRU list.
`timescale 1ns / 1ps
`include "lru_page_window_mapper_core_defines.svh"
//
// channel  direction  handshake              payload
// in       input      in_valid / in_stall    action, page_number, page_offset
// out      output     out_valid / out_stall  virtual_address, new_mapping, mapped_slot,
//                                            evicted, evicted_page, status
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One word at a time: an unlock steps through LOOKUP and DONE, a hit or fresh map through LOOKUP,
// ADDR and DONE, and a map with eviction through LOOKUP, EVICT, INSTALL, ADDR and DONE.
// After reset a clearing pass over every entry of the page flag memory holds in_stall high.
// A result waits in the output register while the next word is accepted;
// a finished word waits in its last step while the output register is full and out_stall is high.
// Configuration writes are taken in every cycle.
module lru_page_window_mapper_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              action,
	input  logic [lpwm_pkg::PAGE_W-1:0]       page_number,
	input  logic [lpwm_pkg::PAGE_BITS-1:0]    page_offset,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [lpwm_pkg::ADDR_W-1:0]       virtual_address,
	output logic                              new_mapping,
	output logic [lpwm_pkg::SLOT_W-1:0]       mapped_slot,
	output logic                              evicted,
	output logic [lpwm_pkg::PAGE_W-1:0]       evicted_page,
	output logic [lpwm_pkg::STATUS_W-1:0]     status,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic                              cfg_index,
	input  logic [lpwm_pkg::ADDR_W-1:0]       cfg_data
);

	lpwm_pkg::lpwm_state_t state_q, state_d;

	logic [lpwm_pkg::PAGE_W-1:0]    clr_q;
	logic [lpwm_pkg::ADDR_W-1:0]    window_base_q;
	logic [lpwm_pkg::AVAIL_W-1:0]   slots_avail_q;
	logic [lpwm_pkg::PAGE_W-1:0]    lru_head_q;
	logic [lpwm_pkg::PAGE_W-1:0]    lru_tail_q;
	logic [lpwm_pkg::COUNT_W-1:0]   lru_count_q;
	logic [lpwm_pkg::USED_W-1:0]    slots_used_q;
	logic                           out_valid_q;

	logic                           act_q;
	logic [lpwm_pkg::PAGE_W-1:0]    page_q;
	logic [lpwm_pkg::PAGE_BITS-1:0] offset_q;
	logic [lpwm_pkg::SLOT_W-1:0]    slot_q;
	logic                           res_new_q;
	logic                           res_ev_q;
	logic [lpwm_pkg::PAGE_W-1:0]    res_evpage_q;
	logic [lpwm_pkg::STATUS_W-1:0]  res_status_q;
	logic [lpwm_pkg::ADDR_W-1:0]    res_addr_q;
	logic [lpwm_pkg::ADDR_W-1:0]    out_addr_q;
	logic                           out_new_q;
	logic [lpwm_pkg::SLOT_W-1:0]    out_slot_q;
	logic                           out_ev_q;
	logic [lpwm_pkg::PAGE_W-1:0]    out_evpage_q;
	logic [lpwm_pkg::STATUS_W-1:0]  out_status_q;

	lpwm_pkg::lpwm_entry_t          flags_mem [lpwm_pkg::NUM_PAGES];
	lpwm_pkg::lpwm_entry_t          flags_rd_q;
	logic [lpwm_pkg::PAGE_W-1:0]    prev_mem [lpwm_pkg::NUM_PAGES];
	logic [lpwm_pkg::PAGE_W-1:0]    prev_rd_q;

	logic                           in_take;
	logic                           out_take;
	logic                           out_free;
	logic [lpwm_pkg::USED_W-1:0]    limit;
	logic                           fresh_ok;
	logic                           count_nz;
	logic                           do_fresh;
	logic                           do_push;
	logic                           map_fail;
	logic                           mem_we;
	logic [lpwm_pkg::PAGE_W-1:0]    mem_waddr;
	lpwm_pkg::lpwm_entry_t          mem_wdata;
	logic [lpwm_pkg::PAGE_W-1:0]    mem_raddr;
	logic                           prev_we;
	lpwm_pkg::lpwm_alu_req_t        alu_req;
	logic [lpwm_pkg::ADDR_W-1:0]    alu_y;

	lpwm_alu u_alu (
		.req (alu_req),
		.y   (alu_y)
	);

	assign in_stall  = (state_q != lpwm_pkg::ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign out_take  = out_valid_q && !out_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	assign limit    = (slots_avail_q > lpwm_pkg::USED_W'(lpwm_pkg::NUM_SLOTS)) ?
		lpwm_pkg::USED_W'(lpwm_pkg::NUM_SLOTS) : lpwm_pkg::USED_W'(slots_avail_q);
	assign fresh_ok = slots_used_q < limit;
	assign count_nz = lru_count_q != '0;
	assign do_fresh = (act_q == lpwm_pkg::ACT_MAP) && !flags_rd_q.mapped && fresh_ok;
	assign map_fail = (act_q == lpwm_pkg::ACT_MAP) && !flags_rd_q.mapped && !fresh_ok
		&& !count_nz;
	assign do_push  = (act_q == lpwm_pkg::ACT_UNLOCK) && flags_rd_q.mapped
		&& !flags_rd_q.unlocked;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lpwm_pkg::ST_CLEAR: begin
				if (clr_q == lpwm_pkg::PAGE_W'(lpwm_pkg::NUM_PAGES - 1)) begin
					state_d = lpwm_pkg::ST_IDLE;
				end
			end
			lpwm_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = lpwm_pkg::ST_LOOKUP;
				end
			end
			lpwm_pkg::ST_LOOKUP: begin
				if (act_q == lpwm_pkg::ACT_MAP) begin
					if (flags_rd_q.mapped || fresh_ok) begin
						state_d = lpwm_pkg::ST_ADDR;
					end else if (count_nz) begin
						state_d = lpwm_pkg::ST_EVICT;
					end else begin
						state_d = lpwm_pkg::ST_DONE;
					end
				end else begin
					state_d = lpwm_pkg::ST_DONE;
				end
			end
			lpwm_pkg::ST_EVICT:   state_d = lpwm_pkg::ST_INSTALL;
			lpwm_pkg::ST_INSTALL: state_d = lpwm_pkg::ST_ADDR;
			lpwm_pkg::ST_ADDR:    state_d = lpwm_pkg::ST_DONE;
			lpwm_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = lpwm_pkg::ST_IDLE;
				end
			end
			default: state_d = lpwm_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = page_q;
		mem_wdata = '0;
		mem_raddr = page_number;
		prev_we   = 1'b0;
		alu_req   = '{op: lpwm_pkg::ALU_ADD, a: window_base_q,
			b: lpwm_pkg::ADDR_W'({slot_q, offset_q})};
		unique case (state_q)
			lpwm_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			lpwm_pkg::ST_LOOKUP: begin
				mem_raddr = lru_tail_q;
				if (do_fresh) begin
					mem_we    = 1'b1;
					mem_wdata = '{mapped: 1'b1, unlocked: 1'b0,
						slot: slots_used_q[lpwm_pkg::SLOT_W-1:0]};
					alu_req   = '{op: lpwm_pkg::ALU_INC,
						a: lpwm_pkg::ADDR_W'(slots_used_q), b: '0};
				end else if (do_push) begin
					mem_we    = 1'b1;
					mem_wdata = '{mapped: 1'b1, unlocked: 1'b1, slot: flags_rd_q.slot};
					prev_we   = count_nz;
					alu_req   = '{op: lpwm_pkg::ALU_INC,
						a: lpwm_pkg::ADDR_W'(lru_count_q), b: '0};
				end
			end
			lpwm_pkg::ST_EVICT: begin
				mem_we    = 1'b1;
				mem_waddr = lru_tail_q;
				mem_wdata = '{mapped: 1'b0, unlocked: 1'b0, slot: flags_rd_q.slot};
				alu_req   = '{op: lpwm_pkg::ALU_DEC,
					a: lpwm_pkg::ADDR_W'(lru_count_q), b: '0};
			end
			lpwm_pkg::ST_INSTALL: begin
				mem_we    = 1'b1;
				mem_wdata = '{mapped: 1'b1, unlocked: 1'b0, slot: slot_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= lpwm_pkg::ST_CLEAR;
			clr_q         <= '0;
			window_base_q <= '0;
			slots_avail_q <= lpwm_pkg::AVAIL_W'(lpwm_pkg::NUM_SLOTS);
			lru_head_q    <= '0;
			lru_tail_q    <= '0;
			lru_count_q   <= '0;
			slots_used_q  <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == lpwm_pkg::ST_CLEAR) begin
				clr_q <= clr_q + lpwm_pkg::PAGE_W'(1);
			end
			if (cfg_valid) begin
				unique case (cfg_index)
					lpwm_pkg::REG_WINDOW_BASE:     window_base_q <= cfg_data;
					lpwm_pkg::REG_SLOTS_AVAILABLE:
						slots_avail_q <= cfg_data[lpwm_pkg::AVAIL_W-1:0];
					default: begin
					end
				endcase
			end
			if (state_q == lpwm_pkg::ST_LOOKUP && do_fresh) begin
				slots_used_q <= alu_y[lpwm_pkg::USED_W-1:0];
			end
			if (state_q == lpwm_pkg::ST_LOOKUP && do_push) begin
				lru_head_q  <= page_q;
				lru_count_q <= alu_y[lpwm_pkg::COUNT_W-1:0];
				if (!count_nz) begin
					lru_tail_q <= page_q;
				end
			end
			if (state_q == lpwm_pkg::ST_EVICT) begin
				lru_count_q <= alu_y[lpwm_pkg::COUNT_W-1:0];
				if (alu_y[lpwm_pkg::COUNT_W-1:0] != '0) begin
					lru_tail_q <= prev_rd_q;
				end
			end
			if (state_q == lpwm_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			act_q        <= action;
			page_q       <= page_number;
			offset_q     <= page_offset;
			slot_q       <= '0;
			res_new_q    <= 1'b0;
			res_ev_q     <= 1'b0;
			res_evpage_q <= '0;
			res_status_q <= lpwm_pkg::STATUS_OK;
			res_addr_q   <= '0;
		end
		unique case (state_q)
			lpwm_pkg::ST_LOOKUP: begin
				if (act_q == lpwm_pkg::ACT_MAP) begin
					if (flags_rd_q.mapped) begin
						slot_q <= flags_rd_q.slot;
					end else if (do_fresh) begin
						slot_q    <= slots_used_q[lpwm_pkg::SLOT_W-1:0];
						res_new_q <= 1'b1;
					end else if (map_fail) begin
						res_status_q <= lpwm_pkg::STATUS_NO_EVICT;
					end
				end else if (!flags_rd_q.mapped) begin
					res_status_q <= lpwm_pkg::STATUS_UNMAPPED;
				end else begin
					slot_q <= flags_rd_q.slot;
				end
			end
			lpwm_pkg::ST_EVICT: begin
				slot_q       <= flags_rd_q.slot;
				res_ev_q     <= 1'b1;
				res_evpage_q <= lru_tail_q;
			end
			lpwm_pkg::ST_INSTALL: res_new_q <= 1'b1;
			lpwm_pkg::ST_ADDR:    res_addr_q <= alu_y;
			default: begin
			end
		endcase
		if (state_q == lpwm_pkg::ST_DONE && out_free) begin
			out_addr_q   <= res_addr_q;
			out_new_q    <= res_new_q;
			out_slot_q   <= slot_q;
			out_ev_q     <= res_ev_q;
			out_evpage_q <= res_evpage_q;
			out_status_q <= res_status_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			flags_mem[mem_waddr] <= mem_wdata;
		end
		flags_rd_q <= flags_mem[mem_raddr];
		if (prev_we) begin
			prev_mem[lru_head_q] <= page_q;
		end
		prev_rd_q <= prev_mem[lru_tail_q];
	end

	assign out_valid       = out_valid_q;
	assign virtual_address = out_addr_q;
	assign new_mapping     = out_new_q;
	assign mapped_slot     = out_slot_q;
	assign evicted         = out_ev_q;
	assign evicted_page    = out_evpage_q;
	assign status          = out_status_q;

	`LPWM_ASSERT_NEXT(a_take_to_lookup, in_take, state_q == lpwm_pkg::ST_LOOKUP)
	`LPWM_ASSERT_NOW(a_evict_needs_list, state_q == lpwm_pkg::ST_EVICT, count_nz)
	`LPWM_ASSERT_NOW(a_used_in_range, 1'b1, slots_used_q <= lpwm_pkg::USED_W'(lpwm_pkg::NUM_SLOTS))
	`LPWM_ASSERT_NOW(a_out_from_done, $rose(out_valid_q), $past(state_q) == lpwm_pkg::ST_DONE)
	`LPWM_ASSERT_NOW(a_fresh_before_full, state_q == lpwm_pkg::ST_EVICT, !fresh_ok)

endmodule
